@@ rtl/psta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psta_pkg
// shared types, codes and sizes of the process slot tree allocator
// ----------------------------------------------------------------------------
package psta_pkg;

   localparam int SLOTS        = 32;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int LINK_W       = $clog2(SLOTS + 1);
   localparam int COUNT_W      = $clog2(SLOTS + 1);
   localparam int CMD_W        = 2;
   localparam int SLOT_FIELD_W = 5;
   localparam int STATUS_W     = 3;

   typedef logic [SLOT_W-1:0]       slot_type;
   typedef logic [LINK_W-1:0]       link_type;
   typedef logic [COUNT_W-1:0]      count_type;
   typedef logic [SLOT_FIELD_W-1:0] slot_field_type;

   localparam link_type LINK_NONE = LINK_W'(SLOTS);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_CHILDREN = 3'd3,
      ST_THREADS  = 3'd4,
      ST_NOCHILD  = 3'd5,
      ST_FREE     = 3'd6
   } status_type;

   typedef struct packed {
      cmd_type        command;
      slot_field_type slot;
      logic           null_handle;
      logic           has_threads;
   } req_type;

   typedef struct packed {
      status_type     status;
      slot_field_type result_slot;
   } rsp_type;

   typedef struct packed {
      logic     pop;
      logic     push;
      slot_type push_slot;
   } stack_ctl_type;

   typedef struct packed {
      logic     empty;
      slot_type top;
   } stack_stat_type;

   function automatic link_type to_link(slot_type s);
      return LINK_W'(s);
   endfunction

   function automatic logic link_valid(link_type l);
      return l < LINK_NONE;
   endfunction

endpackage
`default_nettype wire

@@ rtl/process_slot_tree_allocator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// process_slot_tree_allocator_unit
// pool of process slots: lifo free list plus ordered parent-child links
//
//   channel   ports                                    handshake
//   request   req_command req_slot req_null_handle     start && !busy
//             req_has_threads
//   response  rsp_status rsp_result_slot               rsp_valid, one cycle
//
// one beat per cycle; busy stays low
// response passes through the input register,
// then slot lookup and link update, then the result register
// reset loads the free list and links directly, no clearing pass
// the receiver cannot stall; every response is shown for one cycle
// ----------------------------------------------------------------------------
module process_slot_tree_allocator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic [psta_pkg::CMD_W-1:0]          req_command,
   input  wire logic [psta_pkg::SLOT_FIELD_W-1:0]   req_slot,
   input  wire logic                                req_null_handle,
   input  wire logic                                req_has_threads,
   output      logic                                rsp_valid,
   output      logic [psta_pkg::STATUS_W-1:0]       rsp_status,
   output      logic [psta_pkg::SLOT_FIELD_W-1:0]   rsp_result_slot
);

   logic                     req_valid_ff;
   psta_pkg::req_type        req_ff;
   logic                     rsp_valid_ff;
   psta_pkg::rsp_type        rsp_ff;
   psta_pkg::rsp_type        rsp_in;
   psta_pkg::stack_ctl_type  stack_ctl;
   psta_pkg::stack_stat_type stack_stat;
   logic                     accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.command     <= psta_pkg::cmd_type'(req_command);
         req_ff.slot        <= req_slot;
         req_ff.null_handle <= req_null_handle;
         req_ff.has_threads <= req_has_threads;
      end
      rsp_ff <= rsp_in;
   end

   psta_free_stack u_free_stack (
      .clock      (clock),
      .reset      (reset),
      .stack_ctl  (stack_ctl),
      .stack_stat (stack_stat)
   );

   psta_tree u_tree (
      .clock      (clock),
      .reset      (reset),
      .valid      (req_valid_ff),
      .req        (req_ff),
      .stack_stat (stack_stat),
      .stack_ctl  (stack_ctl),
      .rsp        (rsp_in)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_result_slot = rsp_ff.result_slot;

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("response beat missing two cycles after request");

   a_error_zero_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != psta_pkg::ST_OK) |-> (rsp_result_slot == '0))
      else $error("error response carries a slot");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      stack_ctl.pop |-> !stack_stat.empty && !stack_ctl.push)
      else $error("free list pop while empty or together with push");

   a_ctl_only_with_item: assert property (@(posedge clock) disable iff (reset)
      (stack_ctl.pop || stack_ctl.push) |-> req_valid_ff)
      else $error("free list changed without a request in flight");

endmodule
`default_nettype wire

@@ rtl/psta_free_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psta_free_stack
// lifo of free slot numbers with fill count, one pop or push per cycle
// ----------------------------------------------------------------------------
module psta_free_stack (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire psta_pkg::stack_ctl_type  stack_ctl,
   output      psta_pkg::stack_stat_type stack_stat
);

   psta_pkg::slot_type  stack_ff [psta_pkg::SLOTS];
   psta_pkg::count_type count_ff;
   psta_pkg::slot_type  top_idx;
   logic                empty;
   logic                full;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == psta_pkg::COUNT_W'(psta_pkg::SLOTS));
   assign top_idx = empty ? '0 : psta_pkg::SLOT_W'(count_ff - psta_pkg::COUNT_W'(1));

   assign stack_stat.empty = empty;
   assign stack_stat.top   = stack_ff[top_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < psta_pkg::SLOTS; i++) begin
            stack_ff[i] <= (i < psta_pkg::SLOTS - 1) ?
                           psta_pkg::SLOT_W'(psta_pkg::SLOTS - 1 - i) : '0;
         end
         count_ff <= psta_pkg::COUNT_W'(psta_pkg::SLOTS - 1);
      end else if (stack_ctl.pop && !empty) begin
         count_ff <= count_ff - psta_pkg::COUNT_W'(1);
      end else if (stack_ctl.push && !full) begin
         stack_ff[count_ff[psta_pkg::SLOT_W-1:0]] <= stack_ctl.push_slot;
         count_ff <= count_ff + psta_pkg::COUNT_W'(1);
      end
   end

endmodule
`default_nettype wire

@@ rtl/psta_tree.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psta_tree
// slot link register files, command checks and tree updates for one beat
// ----------------------------------------------------------------------------
module psta_tree (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     valid,
   input  wire psta_pkg::req_type        req,
   input  wire psta_pkg::stack_stat_type stack_stat,
   output      psta_pkg::stack_ctl_type  stack_ctl,
   output      psta_pkg::rsp_type        rsp
);

   logic               in_use_ff [psta_pkg::SLOTS];
   psta_pkg::slot_type parent_ff [psta_pkg::SLOTS];
   psta_pkg::link_type first_ff  [psta_pkg::SLOTS];
   psta_pkg::link_type last_ff   [psta_pkg::SLOTS];
   psta_pkg::link_type next_ff   [psta_pkg::SLOTS];
   psta_pkg::link_type prev_ff   [psta_pkg::SLOTS];

   logic               in_range;
   psta_pkg::slot_type s;
   logic               used;
   psta_pkg::link_type fc;
   psta_pkg::link_type lc;
   psta_pkg::link_type nx;
   psta_pkg::link_type pv;
   psta_pkg::slot_type p;
   psta_pkg::slot_type new_slot;
   logic               do_alloc;
   logic               do_delete;
   logic               is_root;

   assign in_range = (32'(req.slot) < 32'(psta_pkg::SLOTS));
   assign s        = in_range ? psta_pkg::SLOT_W'(req.slot) : '0;
   assign used     = in_use_ff[s];
   assign fc       = first_ff[s];
   assign lc       = last_ff[s];
   assign nx       = next_ff[s];
   assign pv       = prev_ff[s];
   assign p        = parent_ff[s];
   assign new_slot = stack_stat.top;
   // only the parentless root points at itself
   assign is_root  = (p == s);

   always_comb begin
      rsp.status          = psta_pkg::ST_OK;
      rsp.result_slot     = '0;
      stack_ctl.pop       = 1'b0;
      stack_ctl.push      = 1'b0;
      stack_ctl.push_slot = s;
      do_alloc            = 1'b0;
      do_delete           = 1'b0;
      if (valid) begin
         priority if (req.command == psta_pkg::CMD_NOP) begin
            rsp.status = psta_pkg::ST_OK;
         end else if (req.null_handle) begin
            rsp.status = psta_pkg::ST_NULL;
         end else if (!in_range || !used) begin
            rsp.status = psta_pkg::ST_FREE;
         end else begin
            unique case (req.command)
               psta_pkg::CMD_ALLOC: begin
                  if (stack_stat.empty) begin
                     rsp.status = psta_pkg::ST_EMPTY;
                  end else begin
                     stack_ctl.pop = 1'b1;
                     if (new_slot == s) begin
                        rsp.status = psta_pkg::ST_EMPTY;
                     end else begin
                        do_alloc        = 1'b1;
                        rsp.result_slot = psta_pkg::SLOT_FIELD_W'(new_slot);
                     end
                  end
               end
               psta_pkg::CMD_DELETE: begin
                  if (psta_pkg::link_valid(fc)) begin
                     rsp.status = psta_pkg::ST_CHILDREN;
                  end else if (req.has_threads) begin
                     rsp.status = psta_pkg::ST_THREADS;
                  end else begin
                     do_delete      = 1'b1;
                     stack_ctl.push = 1'b1;
                  end
               end
               psta_pkg::CMD_QUERY: begin
                  if (psta_pkg::link_valid(fc)) begin
                     rsp.result_slot = psta_pkg::SLOT_FIELD_W'(fc);
                  end else begin
                     rsp.status = psta_pkg::ST_NOCHILD;
                  end
               end
               psta_pkg::CMD_NOP: begin
                  rsp.status = psta_pkg::ST_OK;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < psta_pkg::SLOTS; i++) begin
            in_use_ff[i] <= (i == 0);
            parent_ff[i] <= '0;
            first_ff[i]  <= psta_pkg::LINK_NONE;
            last_ff[i]   <= psta_pkg::LINK_NONE;
            next_ff[i]   <= psta_pkg::LINK_NONE;
            prev_ff[i]   <= psta_pkg::LINK_NONE;
         end
      end else if (do_alloc) begin
         in_use_ff[new_slot] <= 1'b1;
         parent_ff[new_slot] <= s;
         first_ff[new_slot]  <= psta_pkg::LINK_NONE;
         last_ff[new_slot]   <= psta_pkg::LINK_NONE;
         next_ff[new_slot]   <= psta_pkg::LINK_NONE;
         prev_ff[new_slot]   <= lc;
         if (psta_pkg::link_valid(lc)) begin
            next_ff[psta_pkg::SLOT_W'(lc)] <= psta_pkg::to_link(new_slot);
         end else begin
            first_ff[s] <= psta_pkg::to_link(new_slot);
         end
         last_ff[s] <= psta_pkg::to_link(new_slot);
      end else if (do_delete) begin
         if (psta_pkg::link_valid(pv)) begin
            next_ff[psta_pkg::SLOT_W'(pv)] <= nx;
         end else if (!is_root) begin
            first_ff[p] <= nx;
         end
         if (psta_pkg::link_valid(nx)) begin
            prev_ff[psta_pkg::SLOT_W'(nx)] <= pv;
         end else if (!is_root) begin
            last_ff[p] <= pv;
         end
         parent_ff[s] <= '0;
         prev_ff[s]   <= psta_pkg::LINK_NONE;
         next_ff[s]   <= psta_pkg::LINK_NONE;
         first_ff[s]  <= psta_pkg::LINK_NONE;
         last_ff[s]   <= psta_pkg::LINK_NONE;
         in_use_ff[s] <= 1'b0;
      end
   end

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the process slot tree allocator: a directed
// opener, phases of random tree growth and pruning driven by a lookahead
// copy of the slot pool, a final prune down to the root and a root delete;
// every response is checked against a second copy of the pool updated on
// each accepted command beat
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LOOKAHEAD = 0;
   localparam int TRACKED   = 1;
   localparam int IDLE_PCT  = 31;

   typedef struct {
      psta_pkg::req_type req;
      bit                drain_first;
   } slot_cmd_type;

   logic clock;
   logic reset;
   logic start = 1'b0;
   logic busy;
   logic [psta_pkg::CMD_W-1:0] req_command = psta_pkg::CMD_NOP;
   logic [psta_pkg::SLOT_FIELD_W-1:0] req_slot = '0;
   logic req_null_handle = 1'b0;
   logic req_has_threads = 1'b0;
   logic rsp_valid;
   logic [psta_pkg::STATUS_W-1:0] rsp_status;
   logic [psta_pkg::SLOT_FIELD_W-1:0] rsp_result_slot;

   // two copies of the pool: one steers generation, one predicts responses
   logic                slot_taken  [2][psta_pkg::SLOTS];
   psta_pkg::slot_type  up_link     [2][psta_pkg::SLOTS];
   psta_pkg::link_type  head_kid    [2][psta_pkg::SLOTS];
   psta_pkg::link_type  tail_kid    [2][psta_pkg::SLOTS];
   psta_pkg::link_type  next_sib    [2][psta_pkg::SLOTS];
   psta_pkg::link_type  prev_sib    [2][psta_pkg::SLOTS];
   psta_pkg::slot_type  spare_stack [2][psta_pkg::SLOTS];
   psta_pkg::count_type spare_count [2];

   slot_cmd_type      cmd_backlog[$];
   psta_pkg::rsp_type due_rsp[$];
   int                mismatches = 0;
   int                beats_sent = 0;
   int                rsp_checked = 0;
   int                status_hits[7] = '{default: 0};

   process_slot_tree_allocator_unit uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_slot        (req_slot),
      .req_null_handle (req_null_handle),
      .req_has_threads (req_has_threads),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_result_slot (rsp_result_slot)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #200us;
      $display("process_slot_tree_allocator_unit verification failed");
      $finish;
   end

   function automatic void pool_reset(int v);
      for (int i = 0; i < psta_pkg::SLOTS; i++) begin
         slot_taken[v][i] = 1'b0;
         up_link[v][i]    = '0;
         head_kid[v][i]   = psta_pkg::LINK_NONE;
         tail_kid[v][i]   = psta_pkg::LINK_NONE;
         next_sib[v][i]   = psta_pkg::LINK_NONE;
         prev_sib[v][i]   = psta_pkg::LINK_NONE;
         spare_stack[v][i] = '0;
      end
      for (int i = 0; i + 1 < psta_pkg::SLOTS; i++)
         spare_stack[v][i] = psta_pkg::slot_type'(psta_pkg::SLOTS - 1 - i);
      spare_count[v]   = psta_pkg::count_type'(psta_pkg::SLOTS - 1);
      slot_taken[v][0] = 1'b1;
   endfunction

   function automatic psta_pkg::rsp_type pool_apply(int v, psta_pkg::req_type r);
      psta_pkg::rsp_type  o;
      psta_pkg::slot_type s;
      psta_pkg::slot_type kid;
      psta_pkg::slot_type par;
      psta_pkg::link_type tl;
      psta_pkg::link_type pv;
      psta_pkg::link_type nx;
      o.status      = psta_pkg::ST_OK;
      o.result_slot = '0;
      s = psta_pkg::slot_type'(r.slot);
      if (r.command == psta_pkg::CMD_NOP) return o;
      if (r.null_handle) begin
         o.status = psta_pkg::ST_NULL;
         return o;
      end
      if (!slot_taken[v][s]) begin
         o.status = psta_pkg::ST_FREE;
         return o;
      end
      case (r.command)
         psta_pkg::CMD_ALLOC: begin
            if (spare_count[v] == 0) begin
               o.status = psta_pkg::ST_EMPTY;
            end else begin
               spare_count[v] = spare_count[v] - 1'b1;
               kid = spare_stack[v][spare_count[v]];
               if (kid == s) begin
                  o.status = psta_pkg::ST_EMPTY;
               end else begin
                  slot_taken[v][kid] = 1'b1;
                  up_link[v][kid]    = s;
                  head_kid[v][kid]   = psta_pkg::LINK_NONE;
                  tail_kid[v][kid]   = psta_pkg::LINK_NONE;
                  next_sib[v][kid]   = psta_pkg::LINK_NONE;
                  tl = tail_kid[v][s];
                  prev_sib[v][kid] = tl;
                  if (tl < psta_pkg::LINK_NONE)
                     next_sib[v][tl[psta_pkg::SLOT_W-1:0]] = psta_pkg::link_type'(kid);
                  else head_kid[v][s] = psta_pkg::link_type'(kid);
                  tail_kid[v][s] = psta_pkg::link_type'(kid);
                  o.result_slot = kid;
               end
            end
         end
         psta_pkg::CMD_DELETE: begin
            if (head_kid[v][s] < psta_pkg::LINK_NONE) begin
               o.status = psta_pkg::ST_CHILDREN;
            end else if (r.has_threads) begin
               o.status = psta_pkg::ST_THREADS;
            end else begin
               par = up_link[v][s];
               pv  = prev_sib[v][s];
               nx  = next_sib[v][s];
               if (pv < psta_pkg::LINK_NONE) next_sib[v][pv[psta_pkg::SLOT_W-1:0]] = nx;
               else if (head_kid[v][par] == psta_pkg::link_type'(s)) head_kid[v][par] = nx;
               if (nx < psta_pkg::LINK_NONE) prev_sib[v][nx[psta_pkg::SLOT_W-1:0]] = pv;
               else if (tail_kid[v][par] == psta_pkg::link_type'(s)) tail_kid[v][par] = pv;
               up_link[v][s]    = '0;
               prev_sib[v][s]   = psta_pkg::LINK_NONE;
               next_sib[v][s]   = psta_pkg::LINK_NONE;
               head_kid[v][s]   = psta_pkg::LINK_NONE;
               tail_kid[v][s]   = psta_pkg::LINK_NONE;
               slot_taken[v][s] = 1'b0;
               if (spare_count[v] < psta_pkg::SLOTS) begin
                  spare_stack[v][spare_count[v]] = s;
                  spare_count[v] = spare_count[v] + 1'b1;
               end
            end
         end
         default: begin
            if (head_kid[v][s] < psta_pkg::LINK_NONE)
               o.result_slot = head_kid[v][s][psta_pkg::SLOT_W-1:0];
            else o.status = psta_pkg::ST_NOCHILD;
         end
      endcase
      return o;
   endfunction

   function automatic int pick_taken(int v);
      int cand[$];
      for (int i = 0; i < psta_pkg::SLOTS; i++) if (slot_taken[v][i]) cand.push_back(i);
      if (cand.size() == 0) return 0;
      return cand[$urandom_range(0, cand.size() - 1)];
   endfunction

   // in-use slot other than the root with no children, or -1
   function automatic int pick_leaf(int v);
      int cand[$];
      for (int i = 1; i < psta_pkg::SLOTS; i++)
         if (slot_taken[v][i] && !(head_kid[v][i] < psta_pkg::LINK_NONE)) cand.push_back(i);
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
   endfunction

   function automatic void queue_cmd(psta_pkg::cmd_type c, int s, bit nul, bit thr,
                                     bit drain);
      slot_cmd_type      e;
      psta_pkg::rsp_type ignored;
      e.req.command     = c;
      e.req.slot        = psta_pkg::slot_field_type'(s);
      e.req.null_handle = nul;
      e.req.has_threads = thr;
      e.drain_first     = drain;
      ignored = pool_apply(LOOKAHEAD, e.req);
      cmd_backlog.push_back(e);
   endfunction

   // stimulus
   initial begin
      int roll;
      int tgt;
      int nul;
      int thr;
      bit grow;
      psta_pkg::cmd_type c;
      pool_reset(LOOKAHEAD);

      queue_cmd(psta_pkg::CMD_QUERY, 0, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_ALLOC, 0, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_ALLOC, 0, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_ALLOC, 0, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_ALLOC, 1, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_QUERY, 0, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_QUERY, 1, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_DELETE, 0, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_DELETE, 1, 0, 1, 0);
      queue_cmd(psta_pkg::CMD_DELETE, 4, 0, 1, 0);
      queue_cmd(psta_pkg::CMD_DELETE, 2, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_QUERY, 2, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_ALLOC, 0, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_DELETE, 3, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_DELETE, 2, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_DELETE, 4, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_DELETE, 1, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_QUERY, 0, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_ALLOC, 31, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_DELETE, 31, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_NOP, 31, 1, 1, 0);
      queue_cmd(psta_pkg::CMD_ALLOC, 0, 1, 0, 0);
      queue_cmd(psta_pkg::CMD_QUERY, 0, 1, 1, 0);

      // alternating grow and prune phases so the pool runs dry and refills
      for (int n = 0; n < 1400; n++) begin
         grow = ((n / 100) % 2) == 0;
         roll = $urandom_range(0, 99);
         nul  = 0;
         thr  = ($urandom_range(0, 99) < 15);
         if (roll < (grow ? 60 : 20)) begin
            c   = psta_pkg::CMD_ALLOC;
            tgt = pick_taken(LOOKAHEAD);
         end else if (roll < 75) begin
            c   = psta_pkg::CMD_DELETE;
            tgt = pick_leaf(LOOKAHEAD);
            if (tgt < 0 || $urandom_range(0, 99) < 20) tgt = pick_taken(LOOKAHEAD);
         end else if (roll < 87) begin
            c   = psta_pkg::CMD_QUERY;
            tgt = pick_taken(LOOKAHEAD);
         end else begin
            c   = psta_pkg::cmd_type'($urandom_range(0, 3));
            tgt = $urandom_range(0, psta_pkg::SLOTS - 1);
            nul = $urandom_range(0, 1);
            thr = $urandom_range(0, 1);
         end
         // the root stays alive until the end
         if (c == psta_pkg::CMD_DELETE && tgt == 0 && !nul &&
             !(head_kid[LOOKAHEAD][0] < psta_pkg::LINK_NONE))
            thr = 1;
         queue_cmd(c, tgt, nul, thr, (n % 400) == 0);
      end

      tgt = pick_leaf(LOOKAHEAD);
      while (tgt >= 0) begin
         queue_cmd(psta_pkg::CMD_DELETE, tgt, 0, 0, 0);
         tgt = pick_leaf(LOOKAHEAD);
      end
      queue_cmd(psta_pkg::CMD_DELETE, 0, 0, 1, 1);
      queue_cmd(psta_pkg::CMD_DELETE, 0, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_QUERY, 0, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_ALLOC, 0, 0, 0, 0);
      queue_cmd(psta_pkg::CMD_DELETE, 0, 0, 0, 0);

      @(negedge reset);
      while (cmd_backlog.size() != 0 || start || due_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d command beats sent, %0d responses checked", beats_sent, rsp_checked);
      $display("status mix: ok %0d null %0d empty %0d children %0d threads %0d nochild %0d free %0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4], status_hits[5], status_hits[6]);
      if (mismatches == 0) begin
         $display("process_slot_tree_allocator_unit verification clean");
      end else begin
         $display("process_slot_tree_allocator_unit verification failed");
      end
      $finish;
   end

   // driver
   always @(posedge clock) begin
      psta_pkg::req_type cur;
      slot_cmd_type      nxt;
      bit                quiet;
      if (reset) begin
         start           <= 1'b0;
         req_command     <= psta_pkg::CMD_NOP;
         req_slot        <= '0;
         req_null_handle <= 1'b0;
         req_has_threads <= 1'b0;
         pool_reset(TRACKED);
      end else if (!(start && busy)) begin
         if (start) begin
            cur.command     = psta_pkg::cmd_type'(req_command);
            cur.slot        = req_slot;
            cur.null_handle = req_null_handle;
            cur.has_threads = req_has_threads;
            due_rsp.push_back(pool_apply(TRACKED, cur));
            beats_sent++;
         end
         quiet = beats_sent >= 600 && beats_sent < 800;
         if (cmd_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT) &&
             (!cmd_backlog[0].drain_first || due_rsp.size() == 0)) begin
            nxt = cmd_backlog.pop_front();
            start           <= 1'b1;
            req_command     <= nxt.req.command;
            req_slot        <= nxt.req.slot;
            req_null_handle <= nxt.req.null_handle;
            req_has_threads <= nxt.req.has_threads;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      psta_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (due_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d slot %0d", rsp_status, rsp_result_slot);
         end else begin
            exp_rsp = due_rsp.pop_front();
            rsp_checked++;
            if (exp_rsp.status <= psta_pkg::ST_FREE) status_hits[exp_rsp.status]++;
            if (rsp_status !== exp_rsp.status || rsp_result_slot !== exp_rsp.result_slot) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d mismatch: status exp %0d got %0d, slot exp %0d got %0d",
                           rsp_checked, exp_rsp.status, rsp_status,
                           exp_rsp.result_slot, rsp_result_slot);
            end
         end
      end
   end

endmodule

@@ sim.f @@
rtl/psta_pkg.sv
rtl/psta_free_stack.sv
rtl/psta_tree.sv
rtl/process_slot_tree_allocator_unit.sv
verif/tb_top.sv
